@@ hdl/vtpya_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpya_pkg: shared types and constants for the vector to pitch/yaw block
// Holds the default parameter values, the binary angle type, the result
// payload struct and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vtpya_pkg;

   localparam int COORD_WIDTH_DEF  = 32;
   localparam int CORDIC_STEPS_DEF = 16;

   // Widest coordinate that enters the squaring path; wider inputs are scaled.
   localparam int MAX_PITCH_WIDTH = 32;

   localparam int ANGLE_WIDTH    = 16;
   localparam int ACC_WIDTH      = 34;
   localparam int ANGLE_SHIFT    = 16;
   localparam int ATAN_TABLE_LEN = 24;

   // Accumulator unit is 2^-32 of a full turn, so a quarter turn is 2^30.
   localparam logic signed [ACC_WIDTH-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [ACC_WIDTH-1:0] BAM_ROUND    = 34'sd65535;

   // round(atan(2^-i) * 2^31 / pi)
   localparam logic signed [ACC_WIDTH-1:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10680862,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;

   typedef struct packed {
      angle_type pitch;
      angle_type yaw;
   } rsp_payload_type;

endpackage

@@ hdl/vtpya_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpya_ifs: valid/ready channels of the vector to pitch/yaw block
// The request channel carries one direction vector per item, the response
// channel one pitch/yaw pair per item.
// ----------------------------------------------------------------------------
interface vtpya_req_if #(
   parameter int COORD_WIDTH = vtpya_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vec_x;
   logic signed [COORD_WIDTH-1:0] vec_y;
   logic signed [COORD_WIDTH-1:0] vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface vtpya_rsp_if;
   import vtpya_pkg::*;

   logic      valid;
   logic      ready;
   angle_type pitch;
   angle_type yaw;

   modport source (output valid, output pitch, output yaw, input ready);
   modport sink   (input valid, input pitch, input yaw, output ready);
endinterface

@@ hdl/vector_to_pitch_yaw_angles.sv @@
`timescale 1ns / 1ps
// Depth: the path from request to response is set by the square root stages,
//        one per bit of the horizontal length, followed by the CORDIC stages.
// Throughput: one item per cycle; the response side may hold two items before
//             the request channel is stalled.
// Reset: synchronous, active high; clears all valid bits, payload is left as is.
// ----------------------------------------------------------------------------
// vector_to_pitch_yaw_angles: direction vector to pitch and yaw binary angles
// Pitch is atan2(y, sqrt(x*x + z*z)) and yaw is atan2(-x, -z), both as
// 16-bit binary angles where 0x8000 stands for a half turn.
// ----------------------------------------------------------------------------
module vector_to_pitch_yaw_angles #(
   parameter int COORD_WIDTH  = vtpya_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = vtpya_pkg::CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   vtpya_req_if.sink req_chan,
   vtpya_rsp_if.source rsp_chan
);
   import vtpya_pkg::*;

   // Width of the operands of the squaring path after scaling wide inputs.
   localparam int PW         = (COORD_WIDTH > MAX_PITCH_WIDTH) ? MAX_PITCH_WIDTH
                                                              : COORD_WIDTH;
   // Both CORDICs carry enough headroom for the CORDIC gain and negation.
   localparam int PITCH_WIDTH = PW + 3;
   localparam int YAW_WIDTH   = COORD_WIDTH + 3;
   // Cycles spent in the horizontal length pipeline before the pitch CORDIC.
   localparam int FRONT_DEPTH = PW + 3;

   logic                          pipe_en;
   logic                          accept;

   logic                          hl_valid;
   logic [PW-1:0]                 hl_len;
   logic signed [PW-1:0]          hl_y;

   logic signed [PITCH_WIDTH-1:0] pitch_x;
   logic signed [PITCH_WIDTH-1:0] pitch_y;
   logic                          pitch_valid;
   angle_type                     pitch_angle;

   logic signed [YAW_WIDTH-1:0]   yaw_x;
   logic signed [YAW_WIDTH-1:0]   yaw_y;
   logic                          yaw_cdc_valid;
   angle_type                     yaw_cdc_angle;

   logic                          yaw_vdly_ff [FRONT_DEPTH];
   angle_type                     yaw_dly_ff  [FRONT_DEPTH];
   logic                          yaw_valid;

   rsp_payload_type               result;

   // The whole pipeline moves in lock step; it only stops when the output
   // register and its skid entry both hold items.
   assign req_chan.ready = pipe_en;
   assign accept         = req_chan.valid && pipe_en;

   // Pitch: horizontal length first, then atan2(y, length).
   vtpya_hlen #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_hlen (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (accept),
      .in_x      (req_chan.vec_x),
      .in_y      (req_chan.vec_y),
      .in_z      (req_chan.vec_z),
      .out_valid (hl_valid),
      .out_len   (hl_len),
      .out_y     (hl_y)
   );

   assign pitch_x = PITCH_WIDTH'(hl_len);
   assign pitch_y = PITCH_WIDTH'(hl_y);

   vtpya_cordic #(
      .DATA_WIDTH (PITCH_WIDTH),
      .STEPS      (CORDIC_STEPS)
   ) u_pitch_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (hl_valid),
      .in_x      (pitch_x),
      .in_y      (pitch_y),
      .out_valid (pitch_valid),
      .out_angle (pitch_angle)
   );

   // Yaw: atan2(-x, -z) straight from the request, so it finishes early and
   // waits in a short delay line until the pitch of the same item is ready.
   assign yaw_x = -(YAW_WIDTH'(req_chan.vec_z));
   assign yaw_y = -(YAW_WIDTH'(req_chan.vec_x));

   vtpya_cordic #(
      .DATA_WIDTH (YAW_WIDTH),
      .STEPS      (CORDIC_STEPS)
   ) u_yaw_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (accept),
      .in_x      (yaw_x),
      .in_y      (yaw_y),
      .out_valid (yaw_cdc_valid),
      .out_angle (yaw_cdc_angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_vdly_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         yaw_vdly_ff[0] <= yaw_cdc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         yaw_dly_ff[0] <= yaw_cdc_angle;
      end
   end

   for (genvar k = 1; k < FRONT_DEPTH; k++) begin : g_yaw_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            yaw_vdly_ff[k] <= 1'b0;
         end else if (pipe_en) begin
            yaw_vdly_ff[k] <= yaw_vdly_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            yaw_dly_ff[k] <= yaw_dly_ff[k-1];
         end
      end
   end

   assign yaw_valid    = yaw_vdly_ff[FRONT_DEPTH-1];
   assign result.pitch = pitch_angle;
   assign result.yaw   = yaw_dly_ff[FRONT_DEPTH-1];

   // Output register plus skid entry; also produces the pipeline enable.
   vtpya_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pitch_valid),
      .in_payload (result),
      .pipe_en    (pipe_en),
      .rsp_chan   (rsp_chan)
   );

   // The delayed yaw must line up with the pitch of the same item.
   a_paths_aligned : assert property (@(posedge clock) disable iff (reset)
      yaw_valid == pitch_valid)
      else $error("pitch and yaw paths out of step");

   // The request side is only held off while a response is waiting.
   a_stall_has_cause : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("request stalled with no response pending");

   // Stalling begins only after a response was refused.
   a_stall_start : assert property (@(posedge clock) disable iff (reset)
      $fell(req_chan.ready) |-> $past(rsp_chan.valid && !rsp_chan.ready))
      else $error("request stall began without back pressure");

endmodule

@@ hdl/vtpya_hlen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpya_hlen: horizontal length pipeline
// Computes floor(sqrt(x*x + z*z)) with a magnitude stage, a squaring stage, a sum
// stage and one restoring square root stage per result bit, and carries y alongside.
// ----------------------------------------------------------------------------
module vtpya_hlen #(
   parameter int COORD_WIDTH = vtpya_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic signed [COORD_WIDTH-1:0] in_z,
   output logic                          out_valid,
   output logic [((COORD_WIDTH > vtpya_pkg::MAX_PITCH_WIDTH) ?
                  vtpya_pkg::MAX_PITCH_WIDTH : COORD_WIDTH)-1:0] out_len,
   output logic signed [((COORD_WIDTH > vtpya_pkg::MAX_PITCH_WIDTH) ?
                  vtpya_pkg::MAX_PITCH_WIDTH : COORD_WIDTH)-1:0] out_y
);
   import vtpya_pkg::*;

   localparam int PRE_SHIFT = (COORD_WIDTH > MAX_PITCH_WIDTH) ?
                              (COORD_WIDTH - MAX_PITCH_WIDTH) : 0;
   localparam int PW        = COORD_WIDTH - PRE_SHIFT;
   localparam int SUM_WIDTH = 2 * PW;

   logic [PW-1:0]        px;
   logic [PW-1:0]        pz;
   logic [PW-1:0]        ax_in;
   logic [PW-1:0]        az_in;
   logic signed [PW-1:0] py_in;

   logic [PW-1:0]        ax_ff;
   logic [PW-1:0]        az_ff;
   logic signed [PW-1:0] y1_ff;
   logic                 v1_ff;

   logic [SUM_WIDTH-1:0] sqx_in;
   logic [SUM_WIDTH-1:0] sqz_in;
   logic [SUM_WIDTH-1:0] sqx_ff;
   logic [SUM_WIDTH-1:0] sqz_ff;
   logic signed [PW-1:0] y2_ff;
   logic                 v2_ff;

   logic [SUM_WIDTH-1:0] op_ff  [PW+1];
   logic [SUM_WIDTH-1:0] res_ff [PW+1];
   logic signed [PW-1:0] yq_ff  [PW+1];
   logic                 vq_ff  [PW+1];

   // Stage 1: scale wide inputs down and take magnitudes.
   always_comb begin
      px    = PW'(in_x >>> PRE_SHIFT);
      pz    = PW'(in_z >>> PRE_SHIFT);
      py_in = PW'(in_y >>> PRE_SHIFT);
      ax_in = px[PW-1] ? (~px + PW'(1)) : px;
      az_in = pz[PW-1] ? (~pz + PW'(1)) : pz;
   end

   // Stage 2: squares. The operands are PW-bit magnitudes, zero extended.
   always_comb begin
      sqx_in = SUM_WIDTH'(ax_ff) * SUM_WIDTH'(ax_ff);
      sqz_in = SUM_WIDTH'(az_ff) * SUM_WIDTH'(az_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         vq_ff[0] <= 1'b0;
      end else if (en) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         vq_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff     <= ax_in;
         az_ff     <= az_in;
         y1_ff     <= py_in;
         sqx_ff    <= sqx_in;
         sqz_ff    <= sqz_in;
         y2_ff     <= y1_ff;
         op_ff[0]  <= sqx_ff + sqz_ff;
         res_ff[0] <= '0;
         yq_ff[0]  <= y2_ff;
      end
   end

   // One result bit per stage, highest first.
   for (genvar k = 0; k < PW; k++) begin : g_root
      localparam logic [SUM_WIDTH-1:0] ONE = SUM_WIDTH'(1) << (SUM_WIDTH - 2 - 2 * k);

      logic [SUM_WIDTH:0]   trial;
      logic [SUM_WIDTH-1:0] op_in;
      logic [SUM_WIDTH-1:0] res_in;

      always_comb begin
         trial = {1'b0, res_ff[k]} + {1'b0, ONE};
         if ({1'b0, op_ff[k]} >= trial) begin
            op_in  = op_ff[k] - trial[SUM_WIDTH-1:0];
            res_in = (res_ff[k] >> 1) + ONE;
         end else begin
            op_in  = op_ff[k];
            res_in = res_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vq_ff[k+1] <= 1'b0;
         end else if (en) begin
            vq_ff[k+1] <= vq_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            op_ff[k+1]  <= op_in;
            res_ff[k+1] <= res_in;
            yq_ff[k+1]  <= yq_ff[k];
         end
      end
   end

   assign out_valid = vq_ff[PW];
   assign out_len   = res_ff[PW][PW-1:0];
   assign out_y     = yq_ff[PW];

endmodule

@@ hdl/vtpya_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpya_cordic: pipelined vectoring CORDIC for atan2(y, x)
// A quarter-turn pre-rotation stage, one stage per iteration and a final
// stage that scales the accumulator to a 16-bit binary angle.
// ----------------------------------------------------------------------------
module vtpya_cordic #(
   parameter int DATA_WIDTH = vtpya_pkg::COORD_WIDTH_DEF + 3,
   parameter int STEPS      = vtpya_pkg::CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [DATA_WIDTH-1:0] in_x,
   input  logic signed [DATA_WIDTH-1:0] in_y,
   output logic                         out_valid,
   output vtpya_pkg::angle_type         out_angle
);
   import vtpya_pkg::*;

   localparam int NUM_ITER = (STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : STEPS;

   logic signed [DATA_WIDTH-1:0] x_ff     [NUM_ITER+1];
   logic signed [DATA_WIDTH-1:0] y_ff     [NUM_ITER+1];
   logic signed [ACC_WIDTH-1:0]  acc_ff   [NUM_ITER+1];
   logic                         zero_ff  [NUM_ITER+1];
   logic                         valid_ff [NUM_ITER+1];

   logic signed [DATA_WIDTH-1:0] x0_in;
   logic signed [DATA_WIDTH-1:0] y0_in;
   logic signed [ACC_WIDTH-1:0]  acc0_in;

   logic signed [ACC_WIDTH-1:0]  rnd;
   angle_type                    angle_in;
   angle_type                    angle_ff;
   logic                         out_valid_ff;

   // A vector in the left half plane is turned a quarter turn toward x > 0.
   always_comb begin
      x0_in   = in_x;
      y0_in   = in_y;
      acc0_in = '0;
      if (in_x[DATA_WIDTH-1]) begin
         if (!in_y[DATA_WIDTH-1]) begin
            x0_in   = in_y;
            y0_in   = -in_x;
            acc0_in = QUARTER_TURN;
         end else begin
            x0_in   = -in_y;
            y0_in   = in_x;
            acc0_in = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         acc_ff[0]  <= acc0_in;
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
      end
   end

   for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
      logic signed [DATA_WIDTH-1:0] dx;
      logic signed [DATA_WIDTH-1:0] dy;
      logic signed [DATA_WIDTH-1:0] x_in;
      logic signed [DATA_WIDTH-1:0] y_in;
      logic signed [ACC_WIDTH-1:0]  acc_in;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         if (!y_ff[i][DATA_WIDTH-1]) begin
            x_in   = x_ff[i] + dx;
            y_in   = y_ff[i] - dy;
            acc_in = acc_ff[i] + ATAN_TABLE[i];
         end else begin
            x_in   = x_ff[i] - dx;
            y_in   = y_ff[i] + dy;
            acc_in = acc_ff[i] - ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            acc_ff[i+1]  <= acc_in;
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // Divide by 2^16 rounding toward zero, then keep the low 16 bits so that
   // a half turn wraps to the most negative angle.
   always_comb begin
      rnd = acc_ff[NUM_ITER] + (acc_ff[NUM_ITER][ACC_WIDTH-1] ? BAM_ROUND : '0);
      angle_in = zero_ff[NUM_ITER] ? '0 : rnd[ANGLE_SHIFT +: ANGLE_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[NUM_ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = angle_ff;

endmodule

@@ hdl/vtpya_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpya_skid: output register with one skid entry
// Takes the pipeline's last stage, holds results for the response channel
// and freezes the pipeline only when both entries are full.
// ----------------------------------------------------------------------------
module vtpya_skid (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  vtpya_pkg::rsp_payload_type in_payload,
   output logic                       pipe_en,
   vtpya_rsp_if.source                rsp_chan
);
   import vtpya_pkg::*;

   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   logic            skid_valid_ff;
   logic            skid_valid_in;
   rsp_payload_type skid_data_ff;
   rsp_payload_type skid_data_in;
   logic            push;
   logic            pop;

   assign pipe_en = !skid_valid_ff;
   assign push    = pipe_en && in_valid;
   assign pop     = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = in_payload;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_payload;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.pitch = out_data_ff.pitch;
   assign rsp_chan.yaw   = out_data_ff.yaw;

endmodule
